>>> hdl/abenv_pkg.sv
// Package for the acid-bass envelope generator: command/status structs,
// register index codes, FSM states and coefficient reset values. No dependencies.
`default_nettype none

package abenv_pkg;

    localparam int COEF_BITS = 24;
    localparam int OUT_W     = 25;
    localparam int NUM_REGS  = 8;

    typedef enum logic [2:0] {
        REG_FILTER_ATTACK = 3'd0,
        REG_FILTER_DECAY  = 3'd1,
        REG_ACCENT_DECAY  = 3'd2,
        REG_AMP_ATTACK    = 3'd3,
        REG_AMP_HOLD      = 3'd4,
        REG_AMP_DRAIN     = 3'd5,
        REG_SWEEP_DIS     = 3'd6,
        REG_ACC_SMOOTH    = 3'd7
    } t_reg_idx;

    typedef logic [COEF_BITS-1:0] t_coef;

    localparam t_coef COEF_RESET [NUM_REGS] = '{
        24'd65000, 24'd16768000, 24'd16760000, 24'd126000,
        24'd16776466, 24'd16612000, 24'd16769124, 24'd244000
    };

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        LVL_FILTER,
        LVL_AMP,
        LVL_SWEEP,
        LVL_ACC
    } t_lvl_sel;

    typedef enum logic [3:0] {
        COEF_F_ATT,
        COEF_F_DEC,
        COEF_ACC_DEC,
        COEF_A_ATT,
        COEF_A_HOLD,
        COEF_A_DRAIN,
        COEF_SW_DIS,
        COEF_SW_CHG,
        COEF_ACC_SM
    } t_coef_sel;

    typedef enum logic {
        MODE_SCALE,
        MODE_APPROACH
    } t_mode;

    typedef enum logic [1:0] {
        TGT_ONE,
        TGT_FILTER,
        TGT_ZERO
    } t_tgt_sel;

    typedef struct packed {
        t_lvl_sel  lvl_sel;
        t_coef_sel coef_sel;
        t_mode     mode;
        t_tgt_sel  tgt_sel;
        logic      mul_en;
        logic      wb_en;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic below_one;
        logic reach_thresh;
    } t_dp_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_MUL,
        ST_FILT_WB,
        ST_AMP_MUL,
        ST_AMP_WB,
        ST_SWP_MUL,
        ST_SWP_WB,
        ST_ACC_MUL,
        ST_ACC_WB,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> hdl/abenv_dp.sv
// Datapath: coefficient registers, four level registers, shared multiplier
// and writeback adder, output payload registers. Depends on abenv_pkg.
`default_nettype none

module abenv_dp #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire abenv_pkg::t_reg_idx        i_cfg_index,
    input  wire logic [abenv_pkg::COEF_BITS-1:0] i_cfg_data,
    input  wire abenv_pkg::t_dp_cmd         i_cmd,
    output abenv_pkg::t_dp_sts              o_sts,
    output logic [abenv_pkg::OUT_W-1:0]     o_filter_level,
    output logic [abenv_pkg::OUT_W-1:0]     o_amp_level,
    output logic [abenv_pkg::OUT_W-1:0]     o_sweep_level,
    output logic [abenv_pkg::OUT_W-1:0]     o_accent_amp_level
);
    import abenv_pkg::*;

    localparam int LW = FRAC_BITS + 1;
    localparam int BW = COEF_BITS + 1;
    localparam int PW = LW + BW;
    localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam longint unsigned THRESH_L =
        ((64'd99 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [LW-1:0] LEVEL_THRESH = THRESH_L[LW-1:0];

    t_coef r_coef [NUM_REGS];
    logic [LW-1:0] r_filter, r_amp, r_sweep, r_acc;
    logic [PW-1:0] r_prod;
    logic [LW-1:0] r_base;
    logic          r_up;
    t_mode         r_mode;

    logic [LW-1:0] lvl_cur, tgt, mul_a, step, res;
    logic [BW-1:0] mul_b;
    logic [LW:0]   sum;
    logic          up;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        case (i_cmd.lvl_sel)
            LVL_FILTER: lvl_cur = r_filter;
            LVL_AMP:    lvl_cur = r_amp;
            LVL_SWEEP:  lvl_cur = r_sweep;
            LVL_ACC:    lvl_cur = r_acc;
            default:    lvl_cur = r_filter;
        endcase
        case (i_cmd.tgt_sel)
            TGT_ONE:    tgt = LEVEL_ONE;
            TGT_FILTER: tgt = r_filter;
            default:    tgt = '0;
        endcase
        case (i_cmd.coef_sel)
            COEF_F_ATT:   mul_b = {1'b0, r_coef[REG_FILTER_ATTACK]};
            COEF_F_DEC:   mul_b = {1'b0, r_coef[REG_FILTER_DECAY]};
            COEF_ACC_DEC: mul_b = {1'b0, r_coef[REG_ACCENT_DECAY]};
            COEF_A_ATT:   mul_b = {1'b0, r_coef[REG_AMP_ATTACK]};
            COEF_A_HOLD:  mul_b = {1'b0, r_coef[REG_AMP_HOLD]};
            COEF_A_DRAIN: mul_b = {1'b0, r_coef[REG_AMP_DRAIN]};
            COEF_SW_DIS:  mul_b = {1'b0, r_coef[REG_SWEEP_DIS]};
            // charge fraction: one minus the discharge multiplier
            COEF_SW_CHG:  mul_b = {1'b1, {COEF_BITS{1'b0}}} - {1'b0, r_coef[REG_SWEEP_DIS]};
            COEF_ACC_SM:  mul_b = {1'b0, r_coef[REG_ACC_SMOOTH]};
            default:      mul_b = '0;
        endcase
        up = (tgt >= lvl_cur);
        if (i_cmd.mode == MODE_SCALE) begin
            mul_a = lvl_cur;
        end else if (up) begin
            mul_a = tgt - lvl_cur;
        end else begin
            mul_a = lvl_cur - tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= {{BW{1'b0}}, mul_a} * {{LW{1'b0}}, mul_b};
            r_base <= lvl_cur;
            r_up   <= up;
            r_mode <= i_cmd.mode;
        end
    end

    // step never exceeds the level or the distance to target, so LW bits hold it
    always_comb begin
        step = r_prod[COEF_BITS +: LW];
        sum  = {1'b0, r_base} + {1'b0, step};
        if (r_mode == MODE_SCALE) begin
            res = step;
        end else if (r_up) begin
            res = (sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : sum[LW-1:0];
        end else begin
            res = r_base - step;
        end
    end

    assign o_sts.below_one    = (lvl_cur < LEVEL_ONE);
    assign o_sts.reach_thresh = (res >= LEVEL_THRESH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= '0;
            r_amp    <= '0;
            r_sweep  <= '0;
            r_acc    <= '0;
        end else if (i_cmd.wb_en) begin
            case (i_cmd.lvl_sel)
                LVL_FILTER: r_filter <= res;
                LVL_AMP:    r_amp    <= res;
                LVL_SWEEP:  r_sweep  <= res;
                LVL_ACC:    r_acc    <= res;
                default:    r_filter <= res;
            endcase
        end
    end

    function automatic logic [OUT_W-1:0] to_out(input logic [LW-1:0] v);
        logic [LW+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_filter_level     <= to_out(r_filter);
            o_amp_level        <= to_out(r_amp);
            o_sweep_level      <= to_out(r_sweep);
            o_accent_amp_level <= to_out(r_acc);
        end
    end

endmodule

`default_nettype wire

>>> hdl/abenv_ctrl.sv
// Controller: note/gate flags and the tick sequencer that drives the datapath.
// Depends on abenv_pkg.
`default_nettype none

module abenv_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic               i_accent,
    input  wire logic               i_slide,
    output logic                    o_valid,
    input  wire logic               i_ready,
    input  wire abenv_pkg::t_dp_sts i_sts,
    output abenv_pkg::t_dp_cmd      o_cmd
);
    import abenv_pkg::*;

    t_state r_state, n_state;
    logic r_filter_rising, n_filter_rising;
    logic r_amp_rising, n_amp_rising;
    logic r_gate_high, n_gate_high;
    logic r_accented, n_accented;
    logic r_attack, n_attack;
    logic r_out_valid, n_out_valid;
    logic follow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_filter_rising <= 1'b0;
            r_amp_rising    <= 1'b0;
            r_gate_high     <= 1'b0;
            r_accented      <= 1'b0;
            r_attack        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_filter_rising <= n_filter_rising;
            r_amp_rising    <= n_amp_rising;
            r_gate_high     <= n_gate_high;
            r_accented      <= n_accented;
            r_attack        <= n_attack;
            r_out_valid     <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign follow  = r_accented && r_gate_high;

    always_comb begin
        n_state         = r_state;
        n_filter_rising = r_filter_rising;
        n_amp_rising    = r_amp_rising;
        n_gate_high     = r_gate_high;
        n_accented      = r_accented;
        n_attack        = r_attack;
        n_out_valid     = r_out_valid && !i_ready;
        o_cmd.lvl_sel   = LVL_FILTER;
        o_cmd.coef_sel  = COEF_F_DEC;
        o_cmd.mode      = MODE_SCALE;
        o_cmd.tgt_sel   = TGT_ONE;
        o_cmd.mul_en    = 1'b0;
        o_cmd.wb_en     = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (t_kind'(i_kind))
                        KIND_TICK: n_state = ST_FILT_MUL;
                        KIND_NOTE_ON: begin
                            n_gate_high     = 1'b1;
                            n_accented      = i_accent;
                            n_filter_rising = !i_slide;
                            n_amp_rising    = !i_slide;
                        end
                        KIND_NOTE_OFF: begin
                            n_gate_high     = 1'b0;
                            n_filter_rising = 1'b0;
                            n_amp_rising    = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILT_MUL: begin
                o_cmd.lvl_sel = LVL_FILTER;
                o_cmd.mul_en  = 1'b1;
                if (r_filter_rising && i_sts.below_one) begin
                    o_cmd.mode     = MODE_APPROACH;
                    o_cmd.coef_sel = COEF_F_ATT;
                    n_attack       = 1'b1;
                end else begin
                    o_cmd.coef_sel = r_accented ? COEF_ACC_DEC : COEF_F_DEC;
                    n_attack       = 1'b0;
                end
                n_state = ST_FILT_WB;
            end
            ST_FILT_WB: begin
                o_cmd.lvl_sel = LVL_FILTER;
                o_cmd.wb_en   = 1'b1;
                if (r_attack && i_sts.reach_thresh) begin
                    n_filter_rising = 1'b0;
                end
                n_state = ST_AMP_MUL;
            end
            ST_AMP_MUL: begin
                o_cmd.lvl_sel = LVL_AMP;
                o_cmd.mul_en  = 1'b1;
                n_attack      = 1'b0;
                if (!r_gate_high) begin
                    o_cmd.coef_sel = COEF_A_DRAIN;
                end else if (r_amp_rising && i_sts.below_one) begin
                    o_cmd.mode     = MODE_APPROACH;
                    o_cmd.coef_sel = COEF_A_ATT;
                    n_attack       = 1'b1;
                end else begin
                    o_cmd.coef_sel = COEF_A_HOLD;
                end
                n_state = ST_AMP_WB;
            end
            ST_AMP_WB: begin
                o_cmd.lvl_sel = LVL_AMP;
                o_cmd.wb_en   = 1'b1;
                if (r_attack && i_sts.reach_thresh) begin
                    n_amp_rising = 1'b0;
                end
                n_state = ST_SWP_MUL;
            end
            ST_SWP_MUL: begin
                o_cmd.lvl_sel = LVL_SWEEP;
                o_cmd.mul_en  = 1'b1;
                if (follow) begin
                    o_cmd.mode     = MODE_APPROACH;
                    o_cmd.tgt_sel  = TGT_FILTER;
                    o_cmd.coef_sel = COEF_SW_CHG;
                end else begin
                    o_cmd.coef_sel = COEF_SW_DIS;
                end
                n_state = ST_SWP_WB;
            end
            ST_SWP_WB: begin
                o_cmd.lvl_sel = LVL_SWEEP;
                o_cmd.wb_en   = 1'b1;
                n_state       = ST_ACC_MUL;
            end
            ST_ACC_MUL: begin
                o_cmd.lvl_sel  = LVL_ACC;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mode     = MODE_APPROACH;
                o_cmd.tgt_sel  = follow ? TGT_FILTER : TGT_ZERO;
                o_cmd.coef_sel = COEF_ACC_SM;
                n_state        = ST_ACC_WB;
            end
            ST_ACC_WB: begin
                o_cmd.lvl_sel = LVL_ACC;
                o_cmd.wb_en   = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // wait here while the previous beat is still unclaimed
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/acid_bass_envelope_generator.sv
// Top level of the acid-bass envelope generator: controller plus datapath.
// Depends on abenv_pkg, abenv_ctrl and abenv_dp.
//
// Four exponential envelope levels in unsigned Q1.FRAC_BITS (filter, amplitude,
// accent sweep capacitor, smoothed accent amplitude), driven by a stream of
// event beats: sample tick, note on (accent, slide) and note off. Note events
// and the unused kind code produce no output beat. From its acceptance, a tick
// runs the four level updates in order through one shared multiplier, each as
// a multiply step and a writeback step, and then loads the output register.
// Events are taken only in idle, so the next one waits until a tick is done.
// The sweep and accent amplitude updates see the filter level of the same tick.
// The output register holds a finished beat while the next event is accepted;
// a tick that finishes while that beat is still unclaimed waits for it.
// Coefficients are Q0.24 registers written over the configuration port
// (index 0..7 in the order filter attack, filter decay, accent decay, amp
// attack, amp hold decay, amp drain, sweep discharge, accent smoothing); write
// them only while the block is idle. Output fields are the levels zero
// extended, or masked to 25 bits when FRAC_BITS exceeds 24.
`default_nettype none

module acid_bass_envelope_generator #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // event channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_kind,
    input  wire logic                           i_accent,
    input  wire logic                           i_slide,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [abenv_pkg::OUT_W-1:0]         o_filter_level,
    output logic [abenv_pkg::OUT_W-1:0]         o_amp_level,
    output logic [abenv_pkg::OUT_W-1:0]         o_sweep_level,
    output logic [abenv_pkg::OUT_W-1:0]         o_accent_amp_level,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [abenv_pkg::COEF_BITS-1:0] i_cfg_data
);
    import abenv_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_we;

    // register writes are always taken; the register file has no busy time
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    abenv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .i_accent (i_accent),
        .i_slide  (i_slide),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    abenv_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (t_reg_idx'(i_cfg_index)),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_filter_level     (o_filter_level),
        .o_amp_level        (o_amp_level),
        .o_sweep_level      (o_sweep_level),
        .o_accent_amp_level (o_accent_amp_level)
    );

endmodule

`default_nettype wire

>>> hdl/abenv_checker.sv
// Port-level checker for the envelope generator, bound to the top level.
// Depends on acid_bass_envelope_generator and abenv_pkg.
`default_nettype none

module abenv_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_ready,
    input wire logic [1:0]                     i_kind,
    input wire logic                           o_valid,
    input wire logic                           i_ready,
    input wire logic [abenv_pkg::OUT_W-1:0]    o_filter_level
);
    import abenv_pkg::*;

    logic in_beat;
    assign in_beat = i_valid && o_ready;

    // a stalled result beat stays valid and its filter level holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_filter_level))
        else $error("result beat dropped or changed while stalled");

    // note events never create a result beat
    a_note_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_kind != KIND_TICK) && !o_valid |=> !o_valid)
        else $error("result beat after a note event");

    // a tick occupies the sequencer
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_kind == KIND_TICK) |=> !o_ready)
        else $error("event accepted while a tick is in progress");

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

endmodule

bind acid_bass_envelope_generator abenv_checker u_abenv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_kind         (i_kind),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_filter_level (o_filter_level)
);

`default_nettype wire

>>> tb/sv/abenv_level_checker.sv
// Scoreboard for the acid-bass envelope generator. It mirrors the four envelope
// levels from the event and configuration beats and checks every result beat.
// Depends on abenv_pkg.
`default_nettype none

module abenv_level_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_ev_valid,
    input  wire logic                            i_ev_ready,
    input  wire logic [1:0]                      i_kind,
    input  wire logic                            i_accent,
    input  wire logic                            i_slide,
    input  wire logic                            i_res_valid,
    input  wire logic                            i_res_ready,
    input  wire logic [abenv_pkg::OUT_W-1:0]     i_filter_level,
    input  wire logic [abenv_pkg::OUT_W-1:0]     i_amp_level,
    input  wire logic [abenv_pkg::OUT_W-1:0]     i_sweep_level,
    input  wire logic [abenv_pkg::OUT_W-1:0]     i_accent_amp_level,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [2:0]                      i_cfg_index,
    input  wire logic [abenv_pkg::COEF_BITS-1:0] i_cfg_data,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);
    import abenv_pkg::*;

    localparam int FRAC_BITS = 24;

    typedef bit [OUT_W-1:0] t_lvl;

    typedef struct packed {
        t_lvl filter;
        t_lvl amp;
        t_lvl sweep;
        t_lvl acc;
    } t_levels;

    localparam t_lvl LVL_ONE  = t_lvl'(64'd1 << FRAC_BITS);
    // attack ends at round(0.99 * full scale)
    localparam t_lvl LVL_KNEE = t_lvl'(((64'd99 << FRAC_BITS) + 64'd50) / 64'd100);

    t_coef   coef [NUM_REGS];
    t_lvl    filt_lvl, amp_lvl, sweep_lvl, accamp_lvl;
    bit      filt_attack, amp_attack, gate, accent_on;
    t_levels levels_due [$];
    int      mismatch_cnt;

    function automatic t_lvl clip(bit [63:0] v);
        return (v > 64'(LVL_ONE)) ? LVL_ONE : v[OUT_W-1:0];
    endfunction

    function automatic t_lvl decay(t_lvl lvl, t_coef c);
        bit [63:0] prod;
        prod = 64'(clip(64'(lvl))) * 64'(c);
        return clip(prod >> COEF_BITS);
    endfunction

    // one-pole step toward a target, step = floor(frac * |target - level|)
    function automatic t_lvl glide(t_lvl lvl, t_lvl tgt, t_lvl frac);
        t_lvl      l;
        t_lvl      t;
        bit [63:0] step;
        l = clip(64'(lvl));
        t = clip(64'(tgt));
        if (t >= l) begin
            step = (64'(t - l) * 64'(frac)) >> COEF_BITS;
            return clip(64'(l) + step);
        end
        step = (64'(l - t) * 64'(frac)) >> COEF_BITS;
        return l - step[OUT_W-1:0];
    endfunction

    task automatic apply_event(logic [1:0] kind, logic acc, logic sld);
        bit      follow;
        t_levels lv;
        case (kind)
            KIND_NOTE_ON: begin
                gate        = 1'b1;
                accent_on   = acc;
                filt_attack = !sld;
                amp_attack  = !sld;
            end
            KIND_NOTE_OFF: begin
                gate        = 1'b0;
                filt_attack = 1'b0;
                amp_attack  = 1'b0;
            end
            KIND_TICK: begin
                if (filt_attack && filt_lvl < LVL_ONE) begin
                    filt_lvl = glide(filt_lvl, LVL_ONE, {1'b0, coef[REG_FILTER_ATTACK]});
                    if (filt_lvl >= LVL_KNEE) filt_attack = 1'b0;
                end else begin
                    filt_lvl = decay(filt_lvl, accent_on ? coef[REG_ACCENT_DECAY]
                                                         : coef[REG_FILTER_DECAY]);
                end

                if (!gate) begin
                    amp_lvl = decay(amp_lvl, coef[REG_AMP_DRAIN]);
                end else if (amp_attack && amp_lvl < LVL_ONE) begin
                    amp_lvl = glide(amp_lvl, LVL_ONE, {1'b0, coef[REG_AMP_ATTACK]});
                    if (amp_lvl >= LVL_KNEE) amp_attack = 1'b0;
                end else begin
                    amp_lvl = decay(amp_lvl, coef[REG_AMP_HOLD]);
                end

                // sweep and accent amp track this tick's filter level
                follow = accent_on && gate;
                if (follow) begin
                    sweep_lvl = glide(sweep_lvl, filt_lvl, LVL_ONE - {1'b0, coef[REG_SWEEP_DIS]});
                end else begin
                    sweep_lvl = decay(sweep_lvl, coef[REG_SWEEP_DIS]);
                end
                accamp_lvl = glide(accamp_lvl, follow ? filt_lvl : t_lvl'(0),
                                   {1'b0, coef[REG_ACC_SMOOTH]});

                lv.filter = filt_lvl;
                lv.amp    = amp_lvl;
                lv.sweep  = sweep_lvl;
                lv.acc    = accamp_lvl;
                levels_due.push_back(lv);
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_levels want;
        if (levels_due.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: result beat with nothing expected", $time);
            return;
        end
        want = levels_due.pop_front();
        if (want.filter !== i_filter_level || want.amp !== i_amp_level ||
            want.sweep !== i_sweep_level || want.acc !== i_accent_amp_level) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display({"%0t: level mismatch exp f=%0d a=%0d s=%0d c=%0d",
                          " got f=%0d a=%0d s=%0d c=%0d"},
                         $time, want.filter, want.amp, want.sweep, want.acc,
                         i_filter_level, i_amp_level, i_sweep_level, i_accent_amp_level);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) coef[r] = COEF_RESET[r];
            filt_lvl     = '0;
            amp_lvl      = '0;
            sweep_lvl    = '0;
            accamp_lvl   = '0;
            filt_attack  = 1'b0;
            amp_attack   = 1'b0;
            gate         = 1'b0;
            accent_on    = 1'b0;
            mismatch_cnt = 0;
            levels_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            if (i_cfg_valid && i_cfg_ready) coef[i_cfg_index] = i_cfg_data;
            if (i_ev_valid && i_ev_ready) apply_event(i_kind, i_accent, i_slide);
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= levels_due.size();
    end

endmodule

`default_nettype wire

>>> tb/sv/acid_bass_envelope_generator_tb.sv
// Testbench top for the acid-bass envelope generator: clock, reset, event,
// result and configuration drivers, and the verdict. Depends on abenv_pkg,
// abenv_level_checker and the acid_bass_envelope_generator RTL.
`default_nettype none

module acid_bass_envelope_generator_tb;
    import abenv_pkg::*;

    // kind code the block must swallow without a result
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // ~1450 counted event beats: a directed warm-up plus seven random phases
    localparam int PHASE_BEATS   = 205;
    // a tick runs through the sequencer to its output register; note events are taken in idle
    localparam int SETTLE_CYCLES = 14;
    // watchdog limit in cycles; keep a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum {
        COEFS_RESET,
        COEFS_FULL,
        COEFS_ZERO,
        COEFS_MUSICAL,
        COEFS_WILD
    } t_coef_style;

    logic                 clk;
    logic                 rst_n;
    logic                 ev_valid;
    logic                 ev_ready;
    logic [1:0]           ev_kind;
    logic                 ev_accent;
    logic                 ev_slide;
    logic                 res_valid;
    logic                 res_ready;
    logic [OUT_W-1:0]     filter_level;
    logic [OUT_W-1:0]     amp_level;
    logic [OUT_W-1:0]     sweep_level;
    logic [OUT_W-1:0]     accent_amp_level;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [COEF_BITS-1:0] cfg_data;
    int                   mismatches;
    int                   outstanding;

    // when set, both sides run back to back with no idle cycles
    bit                   fast_phase;

    // coefficient settings after the reset-value phase; extremes first
    t_coef_style coef_plan [6] = '{COEFS_FULL, COEFS_ZERO, COEFS_MUSICAL,
                                   COEFS_WILD, COEFS_MUSICAL, COEFS_RESET};

    acid_bass_envelope_generator dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (ev_valid),
        .o_ready            (ev_ready),
        .i_kind             (ev_kind),
        .i_accent           (ev_accent),
        .i_slide            (ev_slide),
        .o_valid            (res_valid),
        .i_ready            (res_ready),
        .o_filter_level     (filter_level),
        .o_amp_level        (amp_level),
        .o_sweep_level      (sweep_level),
        .o_accent_amp_level (accent_amp_level),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    abenv_level_checker chk (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_ev_valid         (ev_valid),
        .i_ev_ready         (ev_ready),
        .i_kind             (ev_kind),
        .i_accent           (ev_accent),
        .i_slide            (ev_slide),
        .i_res_valid        (res_valid),
        .i_res_ready        (res_ready),
        .i_filter_level     (filter_level),
        .i_amp_level        (amp_level),
        .i_sweep_level      (sweep_level),
        .i_accent_amp_level (accent_amp_level),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Event beat. Called at a rising edge. Valid is only dropped when a gap
    // follows, so back-to-back beats never see a low/high pair in one step.
    task automatic send_event(logic [1:0] k, logic acc, logic sld);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(5, 0);
        if (gap > 0) begin
            ev_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_valid  <= 1'b1;
        ev_kind   <= k;
        ev_accent <= acc;
        ev_slide  <= sld;
        do @(posedge clk); while (!ev_ready);
    endtask

    // ticks carry random accent/slide bits, which the block must ignore
    task automatic send_ticks(int n);
        repeat (n) send_event(KIND_TICK, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
    endtask

    // Stop sending and let the block go idle: every expected beat back, then
    // enough cycles for a trailing note event to retire.
    task automatic drain();
        ev_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all eight coefficient registers; block must be idle.
    task automatic program_coefs(t_coef_style style);
        t_coef val;
        for (int r = 0; r < NUM_REGS; r++) begin
            case (style)
                COEFS_FULL: val = '1;
                COEFS_ZERO: val = '0;
                COEFS_WILD: val = t_coef'($urandom());
                COEFS_MUSICAL: begin
                    // attack/smoothing fractions fast enough to finish within a note,
                    // decays close to one so levels linger
                    if (r == REG_FILTER_ATTACK || r == REG_AMP_ATTACK || r == REG_ACC_SMOOTH)
                        val = t_coef'($urandom_range(1 << 22, 1 << 19));
                    else
                        val = t_coef'($urandom_range((1 << 24) - 1, (1 << 24) - (1 << 17)));
                end
                default: val = COEF_RESET[r];
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= 3'(r);
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random traffic. Mostly whole notes (on, ticks, often off, release ticks),
    // the rest orphan note-offs and stray beats of any kind. Unused-kind beats
    // do not count toward the quota.
    task automatic run_random(int quota);
        int         sent;
        int         n_ticks;
        int         pick;
        logic [1:0] kind_pick;
        sent = 0;
        while (sent < quota) begin
            fast_phase = ($urandom_range(5, 0) == 0);
            pick = $urandom_range(9, 0);
            if (pick < 7) begin
                send_event(KIND_NOTE_ON, 1'($urandom_range(1, 0)), 1'($urandom_range(3, 0) == 0));
                // occasional long note so slow attacks reach the decay phase
                n_ticks = ($urandom_range(7, 0) == 0) ? $urandom_range(150, 60)
                                                      : $urandom_range(30, 1);
                send_ticks(n_ticks);
                sent += n_ticks + 1;
                if ($urandom_range(2, 0) != 0) begin
                    send_event(KIND_NOTE_OFF, 1'($urandom_range(1, 0)),
                               1'($urandom_range(1, 0)));
                    n_ticks = $urandom_range(25, 1);
                    send_ticks(n_ticks);
                    sent += n_ticks + 1;
                end
            end else if (pick == 7) begin
                // note-off with no note-on of its own, then gate-low ticks
                send_event(KIND_NOTE_OFF, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                n_ticks = $urandom_range(20, 1);
                send_ticks(n_ticks);
                sent += n_ticks + 1;
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    kind_pick = 2'($urandom_range(3, 0));
                    send_event(kind_pick, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                    if (kind_pick != KIND_UNUSED) sent++;
                end
            end
        end
    endtask

    // result side: random back-pressure per beat, with ready-low stalls that
    // can also fall before a beat shows up
    initial begin : result_sink
        int stall;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = fast_phase ? 0 : $urandom_range(5, 0);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        rst_n      <= 1'b0;
        ev_valid   <= 1'b0;
        ev_kind    <= KIND_TICK;
        ev_accent  <= 1'b0;
        ev_slide   <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        fast_phase = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed warm-up on reset coefficients: tick from all-zero state,
        // plain attack, accented attack (filter uses accent decay), slide
        // without a new attack, gate-low drain, unused kind, an unaccented slide, and
        // a tick and a note-off with their don't-care bits set.
        send_event(KIND_TICK, 1'b0, 1'b0);
        send_event(KIND_UNUSED, 1'b1, 1'b1);
        send_event(KIND_NOTE_ON, 1'b0, 1'b0);
        send_ticks(2);
        send_event(KIND_NOTE_ON, 1'b1, 1'b0);
        send_ticks(3);
        send_event(KIND_NOTE_ON, 1'b1, 1'b1);
        send_ticks(2);
        send_event(KIND_NOTE_OFF, 1'b0, 1'b0);
        send_ticks(2);
        send_event(KIND_UNUSED, 1'b0, 1'b0);
        send_event(KIND_TICK, 1'b1, 1'b1);
        send_event(KIND_NOTE_ON, 1'b0, 1'b1);
        send_event(KIND_TICK, 1'b0, 1'b0);
        send_event(KIND_NOTE_OFF, 1'b1, 1'b1);
        send_ticks(2);

        // reset-value phase, with one full pause mid-way until the
        // result side has caught up
        run_random(PHASE_BEATS / 2);
        drain();
        run_random(PHASE_BEATS - PHASE_BEATS / 2);

        foreach (coef_plan[p]) begin
            drain();
            program_coefs(coef_plan[p]);
            run_random(PHASE_BEATS);
        end

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hdl/abenv_pkg.sv
hdl/abenv_dp.sv
hdl/abenv_ctrl.sv
hdl/acid_bass_envelope_generator.sv
hdl/abenv_checker.sv
tb/sv/abenv_level_checker.sv
tb/sv/acid_bass_envelope_generator_tb.sv
